// File: hw/rtl/tfdt_pkg.sv
// ----------------------------------------------------------------------------
// tfdt_pkg
// types, constants and a helper function shared by the first-draw test block
// ----------------------------------------------------------------------------
package tfdt_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ROUND_W = 9;

  localparam logic [WORD_W-1:0] SEED_MULT  = 32'h1F1F_1F1F;
  localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_XOR  = 32'd2567483615;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC6_0000;
  // multiplicative inverse of five mod 2^32, and the largest multiple-of-five quotient
  localparam logic [WORD_W-1:0] INV_FIVE   = 32'hCCCC_CCCD;
  localparam logic [WORD_W-1:0] FIVE_LIMIT = 32'h3333_3333;

  localparam logic [ROUND_W-1:0] FIRST_ROUND = 9'd1;
  localparam logic [ROUND_W-1:0] LAST_ROUND  = 9'd397;

  typedef struct packed {
    logic [WORD_W-1:0] x_coord;
    logic [WORD_W-1:0] z_coord;
  } tfdt_in_t;

  typedef struct packed {
    logic              is_selected;
    logic [WORD_W-1:0] draw_word;
  } tfdt_out_t;

  // operands for the shared multiply-add unit: p = a * b + c (mod 2^32)
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
  } tfdt_mul_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_INIT,
    ST_TWIST,
    ST_TEMPER,
    ST_CHECK
  } tfdt_state_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
    logic [WORD_W-1:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: hw/rtl/tfdt_mul_unit.sv
// ----------------------------------------------------------------------------
// tfdt_mul_unit
// shared 32-bit multiply-add, low word of a * b + c
// ----------------------------------------------------------------------------
module tfdt_mul_unit
  import tfdt_pkg::*;
(
  input  tfdt_mul_req_t     req,
  output logic [WORD_W-1:0] prod
);

  logic [WORD_W-1:0] mul_lo;

  assign mul_lo = req.a * req.b;
  assign prod   = mul_lo + req.c;

endmodule

// File: hw/rtl/twister_first_draw_decimal_test_top.sv
// ----------------------------------------------------------------------------
// twister_first_draw_decimal_test_top
// seeded first draw of a 32-bit twister generator with a divide-by-ten test
// ----------------------------------------------------------------------------
// usage
//   - an item (x_coord, z_coord) is taken at a rising edge with start high
//     and busy low; busy then stays high until the result is shown
//   - word 0 = x_coord * 0x1F1F1F1F ^ z_coord, words 1..397 by the init
//     recurrence, then twist of words 0, 1, 397 and tempering
//   - the result (is_selected, draw_word) is on out_item for exactly one
//     cycle with out_valid high; the receiver cannot stall it
//   - steps from the accepting edge to the result: seed, the init rounds,
//     twist, temper, check, then the output register
//   - a new item is taken only once the last result is out; start may be raised in the very
//     cycle the result is shown, since busy is already low then
//   - the item rate is set by the single shared 32-bit multiply-add, which runs
//     every init round back to back; each round needs the previous word
//   - is_selected uses the same unit: even and word * inverse(5) <= 2^32/5
//   - synchronous active-low reset returns to idle with no result pending
// ----------------------------------------------------------------------------
module twister_first_draw_decimal_test_top
  import tfdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  tfdt_in_t  in_item,
  output logic      out_valid,
  output tfdt_out_t out_item
);

  // control state
  tfdt_state_t        state_r, state_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic               out_valid_r, out_valid_nxt;

  // datapath registers
  tfdt_in_t           in_r, in_nxt;
  logic [WORD_W-1:0]  seed_r, seed_nxt;
  logic [WORD_W-1:0]  second_r, second_nxt;
  logic [WORD_W-1:0]  running_r, running_nxt;
  tfdt_out_t          out_item_r, out_item_nxt;

  // shared multiply-add
  tfdt_mul_req_t      mul_req;
  logic [WORD_W-1:0]  mul_prod;

  logic [WORD_W-1:0]  prev_word;
  logic [WORD_W-1:0]  mixed;
  logic [WORD_W-1:0]  twisted;
  logic               take_item;

  tfdt_mul_unit u_mul (
    .req  (mul_req),
    .prod (mul_prod)
  );

  assign take_item = start && (state_r == ST_IDLE);

  // first round works on the seed word, later ones on the running word
  assign prev_word = (round_r == FIRST_ROUND) ? seed_r : running_r;

  // twist of words 0, 1 and 397
  assign mixed   = {seed_r[WORD_W-1], second_r[WORD_W-2:0]};
  assign twisted = running_r ^ (mixed >> 1) ^ (mixed[0] ? TWIST_XOR : '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (take_item) state_nxt = ST_SEED;
      ST_SEED:   state_nxt = ST_INIT;
      ST_INIT:   if (round_r == LAST_ROUND) state_nxt = ST_TWIST;
      ST_TWIST:  state_nxt = ST_TEMPER;
      ST_TEMPER: state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    in_nxt        = in_r;
    round_nxt     = round_r;
    seed_nxt      = seed_r;
    second_nxt    = second_r;
    running_nxt   = running_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = 1'b0;
    mul_req.a     = running_r;
    mul_req.b     = INV_FIVE;
    mul_req.c     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (take_item) in_nxt = in_item;
      end
      ST_SEED: begin
        // word 0 from the coordinates
        mul_req.a = in_r.x_coord;
        mul_req.b = SEED_MULT;
        seed_nxt  = mul_prod ^ in_r.z_coord;
        round_nxt = FIRST_ROUND;
      end
      ST_INIT: begin
        // w[i] = INIT_MULT * (w[i-1] ^ (w[i-1] >> 30)) + i
        mul_req.a   = prev_word ^ (prev_word >> 30);
        mul_req.b   = INIT_MULT;
        mul_req.c   = {{(WORD_W-ROUND_W){1'b0}}, round_r};
        running_nxt = mul_prod;
        if (round_r == FIRST_ROUND) second_nxt = mul_prod;
        round_nxt   = round_r + 1'b1;
      end
      ST_TWIST: begin
        running_nxt = twisted;
      end
      ST_TEMPER: begin
        running_nxt = temper(running_r);
      end
      ST_CHECK: begin
        // divisible by ten: even and divisible by five
        out_item_nxt.draw_word   = running_r;
        out_item_nxt.is_selected = !running_r[0] && (mul_prod <= FIVE_LIMIT);
        out_valid_nxt            = 1'b1;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    seed_r     <= seed_nxt;
    second_r   <= second_nxt;
    running_r  <= running_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: hw/rtl/tfdt_checker.sv
// ----------------------------------------------------------------------------
// tfdt_checker
// port-level checks of the first-draw test block
// ----------------------------------------------------------------------------
module tfdt_checker
  import tfdt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input tfdt_out_t out_item
);

  // accepted item makes the block busy
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  // result strobe lasts one cycle
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // the result shows only once the block is free again
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // finishing an item always delivers its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // an odd word is never selected
  a_odd_not_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.draw_word[0] |-> !out_item.is_selected)
    else $error("odd draw flagged as divisible by ten");

endmodule

bind twister_first_draw_decimal_test_top tfdt_checker u_tfdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
